/* design/opposing_key_pair_resolver_defines.svh */
// ----------------------------------------------------------------------------
// opposing_key_pair_resolver_defines
// Assertion macros shared by the opposing key pair resolver.
// ----------------------------------------------------------------------------
`ifndef OPPOSING_KEY_PAIR_RESOLVER_DEFINES_SVH
`define OPPOSING_KEY_PAIR_RESOLVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OPKR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OPKR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/opkr_pkg.sv */
// ----------------------------------------------------------------------------
// opkr_pkg
// Types and constants of the opposing key pair resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package opkr_pkg;

  localparam int TIME_W     = 32;
  localparam int DIGIT_W    = 2;
  localparam int NUM_DIGITS = TIME_W / DIGIT_W;
  localparam int CNT_W      = $clog2(NUM_DIGITS);
  localparam int MS_W       = 8;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 3;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_SOCD_ENABLE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_SOCD_RANDOMIZE = 3'd1;
  localparam logic [IDX_W-1:0] REG_SOCD_DELAY     = 3'd2;
  localparam logic [IDX_W-1:0] REG_TAP_ENABLE     = 3'd3;
  localparam logic [IDX_W-1:0] REG_TAP_RANDOMIZE  = 3'd4;
  localparam logic [IDX_W-1:0] REG_TAP_DELAY      = 3'd5;
  localparam logic [IDX_W-1:0] REG_TAP_DURATION   = 3'd6;

  typedef enum logic [1:0] {
    SIDE_NONE   = 2'd0,
    SIDE_FIRST  = 2'd1,
    SIDE_SECOND = 2'd2
  } side_e;

  typedef struct packed {
    logic            socd_enable;
    logic            socd_randomize;
    logic [MS_W-1:0] socd_delay;
    logic            tap_enable;
    logic            tap_randomize;
    logic [MS_W-1:0] tap_delay;
    logic [MS_W-1:0] tap_duration;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
  } mod_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
    logic sched_socd;
    logic sched_tap;
  } time_ctrl_t;

  typedef struct packed {
    logic pd_reached;
    logic ts_reached;
    logic te_reached;
  } time_stat_t;

endpackage

`default_nettype wire

/* design/opkr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// opkr_cfg_regs
// APB-style register bank holding the resolver settings.
// ----------------------------------------------------------------------------
`default_nettype none

module opkr_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [opkr_pkg::ADDR_W-1:0] paddr,
  input  logic [opkr_pkg::DATA_W-1:0] pwdata,
  output logic [opkr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output opkr_pkg::cfg_t              cfg_o
);
  import opkr_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SOCD_ENABLE:    cfg_d.socd_enable    = pwdata[0];
        REG_SOCD_RANDOMIZE: cfg_d.socd_randomize = pwdata[0];
        REG_SOCD_DELAY:     cfg_d.socd_delay     = pwdata[MS_W-1:0];
        REG_TAP_ENABLE:     cfg_d.tap_enable     = pwdata[0];
        REG_TAP_RANDOMIZE:  cfg_d.tap_randomize  = pwdata[0];
        REG_TAP_DELAY:      cfg_d.tap_delay      = pwdata[MS_W-1:0];
        REG_TAP_DURATION:   cfg_d.tap_duration   = pwdata[MS_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SOCD_ENABLE:    prdata[0]        = cfg_q.socd_enable;
      REG_SOCD_RANDOMIZE: prdata[0]        = cfg_q.socd_randomize;
      REG_SOCD_DELAY:     prdata[MS_W-1:0] = cfg_q.socd_delay;
      REG_TAP_ENABLE:     prdata[0]        = cfg_q.tap_enable;
      REG_TAP_RANDOMIZE:  prdata[0]        = cfg_q.tap_randomize;
      REG_TAP_DELAY:      prdata[MS_W-1:0] = cfg_q.tap_delay;
      REG_TAP_DURATION:   prdata[MS_W-1:0] = cfg_q.tap_duration;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* design/opkr_mod_serial.sv */
// ----------------------------------------------------------------------------
// opkr_mod_serial
// Digit-serial restoring remainder that turns a random word and a millisecond
// setting into the effective delay in milliseconds.
// ----------------------------------------------------------------------------
`default_nettype none

module opkr_mod_serial (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  opkr_pkg::mod_ctrl_t         ctrl_i,
  input  logic [opkr_pkg::TIME_W-1:0] rnd_i,
  input  logic [opkr_pkg::MS_W-1:0]   ms_i,
  input  logic                        randomize_i,
  output logic [opkr_pkg::MS_W-1:0]   eff_o
);
  import opkr_pkg::*;

  logic [TIME_W-1:0] rnd_sr_q, rnd_sr_d;
  logic [MS_W-1:0]   rem_q, rem_d;

  // The dividend enters most significant bit first, one digit per cycle.
  always_comb begin
    logic [MS_W:0] r9;
    r9       = '0;
    rem_d    = rem_q;
    rnd_sr_d = rnd_sr_q;
    if (ctrl_i.load) begin
      rem_d    = '0;
      rnd_sr_d = rnd_i;
    end else if (ctrl_i.step) begin
      for (int k = 0; k < DIGIT_W; k++) begin
        r9 = {rem_d, rnd_sr_q[TIME_W-1-k]};
        if (r9 >= {1'b0, ms_i}) begin
          r9 = r9 - {1'b0, ms_i};
        end
        rem_d = r9[MS_W-1:0];
      end
      rnd_sr_d = {rnd_sr_q[TIME_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  // The remainder stays below the setting, so one more still fits the width.
  assign eff_o = (randomize_i && (ms_i > MS_W'(1))) ? MS_W'(rem_q + MS_W'(1)) : ms_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_sr_q <= rnd_sr_d;
  end

endmodule

`default_nettype wire

/* design/opkr_time_serial.sv */
// ----------------------------------------------------------------------------
// opkr_time_serial
// Digit-serial tick arithmetic: new deadlines and the wrap-safe deadline
// compares, with the deadline registers rotating through the adders.
// ----------------------------------------------------------------------------
`default_nettype none

module opkr_time_serial #(
  parameter int DLY_W = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  opkr_pkg::time_ctrl_t        ctrl_i,
  input  logic [opkr_pkg::TIME_W-1:0] now_i,
  input  logic [DLY_W-1:0]            d_socd_i,
  input  logic [DLY_W-1:0]            d_tap_i,
  input  logic [DLY_W-1:0]            d_len_i,
  output opkr_pkg::time_stat_t        stat_o
);
  import opkr_pkg::*;

  logic [TIME_W-1:0] now_sr_q, now_sr_d;
  logic [DLY_W-1:0]  ds_sr_q, ds_sr_d, dt_sr_q, dt_sr_d, dl_sr_q, dl_sr_d;
  logic [TIME_W-1:0] pdl_q, pdl_d, ts_q, ts_d, te_q, te_d;
  logic [5:0]        cy_q, cy_d;
  logic [2:0]        msb_q, msb_d;

  // Carries: pending sum, tap start sum, tap end sum, then three borrows of
  // now minus the pending deadline, tap start and tap end.
  always_comb begin
    logic             c_nd, c_ts, c_te, b_pd, b_ts, b_te;
    logic             n, s_nd, s_ts, s_te, t_ts, t_te, d_pd, d_ts, d_te;
    logic [DIGIT_W-1:0] nd_dig, ts_dig, te_dig;
    c_nd = cy_q[0]; c_ts = cy_q[1]; c_te = cy_q[2];
    b_pd = cy_q[3]; b_ts = cy_q[4]; b_te = cy_q[5];
    n = 1'b0; s_nd = 1'b0; s_ts = 1'b0; s_te = 1'b0; t_ts = 1'b0; t_te = 1'b0;
    d_pd = 1'b0; d_ts = 1'b0; d_te = 1'b0;
    nd_dig = '0; ts_dig = '0; te_dig = '0;
    now_sr_d = now_sr_q;
    ds_sr_d  = ds_sr_q;
    dt_sr_d  = dt_sr_q;
    dl_sr_d  = dl_sr_q;
    pdl_d    = pdl_q;
    ts_d     = ts_q;
    te_d     = te_q;
    cy_d     = cy_q;
    msb_d    = msb_q;
    if (ctrl_i.load) begin
      now_sr_d = now_i;
      ds_sr_d  = d_socd_i;
      dt_sr_d  = d_tap_i;
      dl_sr_d  = d_len_i;
      cy_d     = 6'b111000;
    end else if (ctrl_i.step) begin
      for (int k = 0; k < DIGIT_W; k++) begin
        n    = now_sr_q[k];
        s_nd = n ^ ds_sr_q[k] ^ c_nd;
        c_nd = (n & ds_sr_q[k]) | (c_nd & (n ^ ds_sr_q[k]));
        s_ts = n ^ dt_sr_q[k] ^ c_ts;
        c_ts = (n & dt_sr_q[k]) | (c_ts & (n ^ dt_sr_q[k]));
        s_te = s_ts ^ dl_sr_q[k] ^ c_te;
        c_te = (s_ts & dl_sr_q[k]) | (c_te & (s_ts ^ dl_sr_q[k]));
        t_ts = ctrl_i.sched_tap ? s_ts : ts_q[k];
        t_te = ctrl_i.sched_tap ? s_te : te_q[k];
        d_pd = n ^ ~pdl_q[k] ^ b_pd;
        b_pd = (n & ~pdl_q[k]) | (b_pd & (n ^ ~pdl_q[k]));
        d_ts = n ^ ~t_ts ^ b_ts;
        b_ts = (n & ~t_ts) | (b_ts & (n ^ ~t_ts));
        d_te = n ^ ~t_te ^ b_te;
        b_te = (n & ~t_te) | (b_te & (n ^ ~t_te));
        nd_dig[k] = ctrl_i.sched_socd ? s_nd : pdl_q[k];
        ts_dig[k] = t_ts;
        te_dig[k] = t_te;
      end
      cy_d     = {b_te, b_ts, b_pd, c_te, c_ts, c_nd};
      // After the last digit these hold bit 31 of each difference.
      msb_d    = {d_te, d_ts, d_pd};
      now_sr_d = now_sr_q >> DIGIT_W;
      ds_sr_d  = ds_sr_q >> DIGIT_W;
      dt_sr_d  = dt_sr_q >> DIGIT_W;
      dl_sr_d  = dl_sr_q >> DIGIT_W;
      pdl_d    = {nd_dig, pdl_q[TIME_W-1:DIGIT_W]};
      ts_d     = {ts_dig, ts_q[TIME_W-1:DIGIT_W]};
      te_d     = {te_dig, te_q[TIME_W-1:DIGIT_W]};
    end
  end

  assign stat_o.pd_reached = ~msb_q[0];
  assign stat_o.ts_reached = ~msb_q[1];
  assign stat_o.te_reached = ~msb_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pdl_q <= '0;
      ts_q  <= '0;
      te_q  <= '0;
      cy_q  <= '0;
      msb_q <= '0;
    end else begin
      pdl_q <= pdl_d;
      ts_q  <= ts_d;
      te_q  <= te_d;
      cy_q  <= cy_d;
      msb_q <= msb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_sr_q <= now_sr_d;
    ds_sr_q  <= ds_sr_d;
    dt_sr_q  <= dt_sr_d;
    dl_sr_q  <= dl_sr_d;
  end

endmodule

`default_nettype wire

/* design/opposing_key_pair_resolver.sv */
// ----------------------------------------------------------------------------
// opposing_key_pair_resolver
// SOCD cleaner with last-input priority and a synthetic reverse tap.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        input      in_valid_i / in_ready_o   keys, now tick, random words
//  out       output     out_valid_o / out_ready_i first_out_o, second_out_o
//  cfg       input      APB write, pready high    seven setting registers
//
//  An item goes from acceptance to a valid result through the remainder units
//  at two bits a cycle, a step that scales the delays, the serial tick adders
//  at two bits a cycle, and one commit.
//  One item is in work at a time; the next one is taken once the result is
//  in the output register, even while that result still waits.
//  Reset clears the settings, the key history and all side state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "opposing_key_pair_resolver_defines.svh"

module opposing_key_pair_resolver #(
  parameter int TICKS_PER_MS = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        first_pressed_i,
  input  logic                        second_pressed_i,
  input  logic [opkr_pkg::TIME_W-1:0] now_tick_i,
  input  logic [opkr_pkg::TIME_W-1:0] rand_socd_i,
  input  logic [opkr_pkg::TIME_W-1:0] rand_tap_delay_i,
  input  logic [opkr_pkg::TIME_W-1:0] rand_tap_length_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        first_out_o,
  output logic                        second_out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [opkr_pkg::ADDR_W-1:0] paddr,
  input  logic [opkr_pkg::DATA_W-1:0] pwdata,
  output logic [opkr_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import opkr_pkg::*;

  localparam int DLY_W = $clog2(255 * TICKS_PER_MS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_DLY  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_DIGITS - 1);

  cfg_t        cfg;
  mod_ctrl_t   mod_ctrl;
  time_ctrl_t  time_ctrl;
  time_stat_t  time_stat;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              f_q, s_q, now_en;
  logic [TIME_W-1:0] now_q;
  logic              prev_first_q, prev_second_q;
  side_e             active_q, active_d, pending_q, pending_d, tap_side_q, tap_side_d;
  logic              out_valid_q, out_valid_d, fo_q, so_q, fo_d, so_d;
  logic              commit;
  logic [MS_W-1:0]   eff_socd, eff_tap, eff_len;
  logic [DLY_W-1:0]  d_socd, d_tap, d_len;
  logic              fnew, snew, frel, srel;

  opkr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  opkr_mod_serial u_mod_socd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mod_ctrl),
    .rnd_i       (rand_socd_i),
    .ms_i        (cfg.socd_delay),
    .randomize_i (cfg.socd_randomize),
    .eff_o       (eff_socd)
  );

  opkr_mod_serial u_mod_tap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mod_ctrl),
    .rnd_i       (rand_tap_delay_i),
    .ms_i        (cfg.tap_delay),
    .randomize_i (cfg.tap_randomize),
    .eff_o       (eff_tap)
  );

  opkr_mod_serial u_mod_len (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mod_ctrl),
    .rnd_i       (rand_tap_length_i),
    .ms_i        (cfg.tap_duration),
    .randomize_i (cfg.tap_randomize),
    .eff_o       (eff_len)
  );

  // Milliseconds to ticks; the product is registered in the serial unit.
  assign d_socd = DLY_W'(DLY_W'(eff_socd) * DLY_W'(TICKS_PER_MS));
  assign d_tap  = DLY_W'(DLY_W'(eff_tap) * DLY_W'(TICKS_PER_MS));
  assign d_len  = DLY_W'(DLY_W'(eff_len) * DLY_W'(TICKS_PER_MS));

  opkr_time_serial #(
    .DLY_W (DLY_W)
  ) u_time (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (time_ctrl),
    .now_i    (now_q),
    .d_socd_i (d_socd),
    .d_tap_i  (d_tap),
    .d_len_i  (d_len),
    .stat_o   (time_stat)
  );

  assign fnew = f_q & ~prev_first_q;
  assign snew = s_q & ~prev_second_q;
  assign frel = prev_first_q & ~f_q;
  assign srel = prev_second_q & ~s_q;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    in_ready_o     = 1'b0;
    now_en         = 1'b0;
    mod_ctrl       = '0;
    time_ctrl.load = 1'b0;
    time_ctrl.step = 1'b0;
    // A new pending deadline is written only when a fresh opposing press has
    // to wait; the tap window is rewritten when exactly one key was released.
    time_ctrl.sched_socd = cfg.socd_enable & f_q & s_q & (fnew ^ snew) &
                           (cfg.socd_delay != '0);
    time_ctrl.sched_tap  = cfg.tap_enable & ~f_q & ~s_q & (frel ^ srel);
    commit         = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          now_en        = 1'b1;
          mod_ctrl.load = 1'b1;
          cnt_d         = '0;
          state_d       = S_MOD;
        end
      end
      S_MOD: begin
        mod_ctrl.step = 1'b1;
        cnt_d         = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = S_DLY;
        end
      end
      S_DLY: begin
        time_ctrl.load = 1'b1;
        cnt_d          = '0;
        state_d        = S_ADD;
      end
      S_ADD: begin
        time_ctrl.step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Side resolution and tap handling for the item in work.
  always_comb begin
    side_e side;
    side       = SIDE_NONE;
    active_d   = active_q;
    pending_d  = pending_q;
    tap_side_d = tap_side_q;
    fo_d       = f_q;
    so_d       = s_q;
    if (cfg.socd_enable) begin
      if (!f_q && !s_q) begin
        active_d  = SIDE_NONE;
        pending_d = SIDE_NONE;
        side      = SIDE_NONE;
      end else if (!f_q || !s_q) begin
        pending_d = SIDE_NONE;
        active_d  = f_q ? SIDE_FIRST : SIDE_SECOND;
        side      = active_d;
      end else if (fnew != snew) begin
        if (cfg.socd_delay == '0) begin
          active_d  = fnew ? SIDE_FIRST : SIDE_SECOND;
          pending_d = SIDE_NONE;
          side      = active_d;
        end else begin
          active_d  = SIDE_NONE;
          pending_d = fnew ? SIDE_FIRST : SIDE_SECOND;
          side      = SIDE_NONE;
        end
      end else if (pending_q != SIDE_NONE) begin
        if (!time_stat.pd_reached) begin
          active_d = SIDE_NONE;
          side     = SIDE_NONE;
        end else begin
          active_d  = pending_q;
          pending_d = SIDE_NONE;
          side      = pending_q;
        end
      end else begin
        if (active_q == SIDE_NONE) begin
          if (fnew) begin
            active_d = SIDE_FIRST;
          end else if (snew) begin
            active_d = SIDE_SECOND;
          end else if (prev_first_q && !prev_second_q) begin
            active_d = SIDE_FIRST;
          end else begin
            active_d = SIDE_SECOND;
          end
        end
        side = active_d;
      end
      fo_d = (side == SIDE_FIRST);
      so_d = (side == SIDE_SECOND);
    end else begin
      pending_d = SIDE_NONE;
      if (f_q && !s_q) begin
        active_d = SIDE_FIRST;
      end else if (!f_q && s_q) begin
        active_d = SIDE_SECOND;
      end else if (!f_q && !s_q) begin
        active_d = SIDE_NONE;
      end
    end

    if (!cfg.tap_enable || f_q || s_q) begin
      tap_side_d = SIDE_NONE;
    end else begin
      if (frel ^ srel) begin
        if (cfg.tap_duration == '0) begin
          tap_side_d = SIDE_NONE;
        end else begin
          tap_side_d = frel ? SIDE_SECOND : SIDE_FIRST;
        end
      end
      if (tap_side_d != SIDE_NONE && time_stat.ts_reached) begin
        if (!time_stat.te_reached) begin
          if (tap_side_d == SIDE_FIRST) begin
            fo_d = 1'b1;
          end else begin
            so_d = 1'b1;
          end
        end else begin
          tap_side_d = SIDE_NONE;
        end
      end
    end
  end

  assign out_valid_d = (out_valid_q & ~out_ready_i) | commit;
  assign out_valid_o = out_valid_q;
  assign first_out_o = fo_q;
  assign second_out_o = so_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      prev_first_q  <= 1'b0;
      prev_second_q <= 1'b0;
      active_q      <= SIDE_NONE;
      pending_q     <= SIDE_NONE;
      tap_side_q    <= SIDE_NONE;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        prev_first_q  <= f_q;
        prev_second_q <= s_q;
        active_q      <= active_d;
        pending_q     <= pending_d;
        tap_side_q    <= tap_side_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (now_en) begin
      f_q   <= first_pressed_i;
      s_q   <= second_pressed_i;
      now_q <= now_tick_i;
    end
    if (commit) begin
      fo_q <= fo_d;
      so_q <= so_d;
    end
  end

  `OPKR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input taken while an item is in work")
  `OPKR_ASSERT_IMPL(a_result_from_commit, clk_i, rst_ni, $rose(out_valid_o), $past(state_q) == S_FIN, "result raised without a commit")
  `OPKR_ASSERT_IMPL(a_pending_blocks_active, clk_i, rst_ni, pending_q != SIDE_NONE, active_q == SIDE_NONE, "pending side held with an active winner")

endmodule

`default_nettype wire

/* test/resolved_keys_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resolved_keys_checker
// Follows the settings written over APB and mirrors the resolver's key state.
// For every accepted scan it predicts the resolved key pair and compares each
// accepted result against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module resolved_keys_checker #(
  parameter int TICKS_PER_MS = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  logic                        first_pressed_i,
  input  logic                        second_pressed_i,
  input  logic [opkr_pkg::TIME_W-1:0] now_tick_i,
  input  logic [opkr_pkg::TIME_W-1:0] rand_socd_i,
  input  logic [opkr_pkg::TIME_W-1:0] rand_tap_delay_i,
  input  logic [opkr_pkg::TIME_W-1:0] rand_tap_length_i,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic                        first_out_o,
  input  logic                        second_out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [opkr_pkg::ADDR_W-1:0] paddr,
  input  logic [opkr_pkg::DATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          fail_count_o,
  output int                          expect_depth_o
);
  import opkr_pkg::*;

  typedef struct packed {
    logic first;
    logic second;
  } key_pair_t;

  cfg_t              settings;
  logic              prev_first;
  logic              prev_second;
  side_e             kept_side;
  side_e             queued_side;
  side_e             tap_side;
  logic [TIME_W-1:0] pending_deadline;
  logic [TIME_W-1:0] tap_start;
  logic [TIME_W-1:0] tap_end;
  key_pair_t         resolved_keys_due[$];
  key_pair_t         due;
  key_pair_t         seen;

  // A deadline counts as reached once the wrapped difference is non-negative.
  function automatic logic deadline_hit(logic [TIME_W-1:0] now, logic [TIME_W-1:0] target);
    logic [TIME_W-1:0] diff;
    diff = now - target;
    return !diff[TIME_W-1];
  endfunction

  function automatic logic [TIME_W-1:0] delay_in_ticks(logic [MS_W-1:0] ms, logic randomize,
                                                       logic [TIME_W-1:0] word);
    logic [TIME_W-1:0] span;
    span = {{(TIME_W-MS_W){1'b0}}, ms};
    if (randomize && span > 32'd1) begin
      span = (word % span) + 32'd1;
    end
    return span * 32'(TICKS_PER_MS);
  endfunction

  function automatic void clear_tap();
    tap_side  = SIDE_NONE;
    tap_start = '0;
    tap_end   = '0;
  endfunction

  function automatic void schedule_tap(side_e side, logic [TIME_W-1:0] now,
                                       logic [TIME_W-1:0] delay_word,
                                       logic [TIME_W-1:0] length_word);
    logic [TIME_W-1:0] lead;
    logic [TIME_W-1:0] hold;
    lead = delay_in_ticks(settings.tap_delay, settings.tap_randomize, delay_word);
    hold = delay_in_ticks(settings.tap_duration, settings.tap_randomize, length_word);
    if (hold == 0) begin
      tap_side = SIDE_NONE;
    end else begin
      tap_side = side;
    end
    tap_start = now + lead;
    tap_end   = now + lead + hold;
  endfunction

  function automatic side_e resolve_socd(logic f, logic s, logic [TIME_W-1:0] now,
                                         logic [TIME_W-1:0] word);
    logic              f_new;
    logic              s_new;
    logic [TIME_W-1:0] wait_ticks;
    f_new = f & ~prev_first;
    s_new = s & ~prev_second;
    if (!f && !s) begin
      kept_side   = SIDE_NONE;
      queued_side = SIDE_NONE;
      return SIDE_NONE;
    end
    if (!f || !s) begin
      queued_side = SIDE_NONE;
      if (f) begin
        kept_side = SIDE_FIRST;
      end else begin
        kept_side = SIDE_SECOND;
      end
      return kept_side;
    end
    // Exactly one key has just gone down: it takes over, maybe after a delay.
    if (f_new != s_new) begin
      wait_ticks = delay_in_ticks(settings.socd_delay, settings.socd_randomize, word);
      if (wait_ticks == 0) begin
        if (f_new) begin
          kept_side = SIDE_FIRST;
        end else begin
          kept_side = SIDE_SECOND;
        end
        queued_side = SIDE_NONE;
        return kept_side;
      end
      kept_side = SIDE_NONE;
      if (f_new) begin
        queued_side = SIDE_FIRST;
      end else begin
        queued_side = SIDE_SECOND;
      end
      pending_deadline = now + wait_ticks;
      return SIDE_NONE;
    end
    if (queued_side != SIDE_NONE) begin
      if (!deadline_hit(now, pending_deadline)) begin
        kept_side = SIDE_NONE;
        return SIDE_NONE;
      end
      kept_side   = queued_side;
      queued_side = SIDE_NONE;
      return kept_side;
    end
    if (kept_side == SIDE_NONE) begin
      if (f_new) begin
        kept_side = SIDE_FIRST;
      end else if (s_new) begin
        kept_side = SIDE_SECOND;
      end else if (prev_first && !prev_second) begin
        kept_side = SIDE_FIRST;
      end else begin
        kept_side = SIDE_SECOND;
      end
    end
    return kept_side;
  endfunction

  function automatic key_pair_t resolve_scan(logic f, logic s, logic [TIME_W-1:0] now,
                                             logic [TIME_W-1:0] socd_word,
                                             logic [TIME_W-1:0] delay_word,
                                             logic [TIME_W-1:0] length_word);
    key_pair_t keys;
    side_e     winner;
    logic      f_rel;
    logic      s_rel;
    if (settings.socd_enable) begin
      winner      = resolve_socd(f, s, now, socd_word);
      keys.first  = (winner == SIDE_FIRST);
      keys.second = (winner == SIDE_SECOND);
    end else begin
      // Pass-through: the winner is only tracked and holds while both are down.
      queued_side = SIDE_NONE;
      if (f && !s) begin
        kept_side = SIDE_FIRST;
      end else if (!f && s) begin
        kept_side = SIDE_SECOND;
      end else if (!f && !s) begin
        kept_side = SIDE_NONE;
      end
      keys.first  = f;
      keys.second = s;
    end
    if (!settings.tap_enable) begin
      clear_tap();
    end else begin
      f_rel = prev_first & ~f;
      s_rel = prev_second & ~s;
      if (f || s) begin
        clear_tap();
      end else if (f_rel && !s_rel) begin
        schedule_tap(SIDE_SECOND, now, delay_word, length_word);
      end else if (s_rel && !f_rel) begin
        schedule_tap(SIDE_FIRST, now, delay_word, length_word);
      end
      if (!f && !s && tap_side != SIDE_NONE && deadline_hit(now, tap_start)) begin
        if (deadline_hit(now, tap_end)) begin
          clear_tap();
        end else if (tap_side == SIDE_FIRST) begin
          keys.first = 1'b1;
        end else if (tap_side == SIDE_SECOND) begin
          keys.second = 1'b1;
        end
      end
    end
    prev_first  = f;
    prev_second = s;
    return keys;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings         = '0;
      prev_first       = 1'b0;
      prev_second      = 1'b0;
      kept_side        = SIDE_NONE;
      queued_side      = SIDE_NONE;
      pending_deadline = '0;
      clear_tap();
      resolved_keys_due.delete();
      fail_count_o     = 0;
      expect_depth_o   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_SOCD_ENABLE:    settings.socd_enable    = pwdata[0];
          REG_SOCD_RANDOMIZE: settings.socd_randomize = pwdata[0];
          REG_SOCD_DELAY:     settings.socd_delay     = pwdata[MS_W-1:0];
          REG_TAP_ENABLE:     settings.tap_enable     = pwdata[0];
          REG_TAP_RANDOMIZE:  settings.tap_randomize  = pwdata[0];
          REG_TAP_DELAY:      settings.tap_delay      = pwdata[MS_W-1:0];
          REG_TAP_DURATION:   settings.tap_duration   = pwdata[MS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        seen.first  = first_out_o;
        seen.second = second_out_o;
        if (resolved_keys_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: result first=%b second=%b arrived with no scan outstanding",
                     $time, seen.first, seen.second);
          end
        end else begin
          due = resolved_keys_due.pop_front();
          if (seen.first !== due.first || seen.second !== due.second) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: mismatch: expected first=%b second=%b, got first=%b second=%b",
                       $time, due.first, due.second, seen.first, seen.second);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        resolved_keys_due.push_back(resolve_scan(first_pressed_i, second_pressed_i, now_tick_i,
                                                 rand_socd_i, rand_tap_delay_i,
                                                 rand_tap_length_i));
      end
      expect_depth_o = resolved_keys_due.size();
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives scans and setting changes into the opposing key pair resolver.
// A short directed run walks through the SOCD and reverse tap corner cases,
// then random key walks run under a series of settings with varying
// back-pressure. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import opkr_pkg::*;

  localparam int               TICKS_PER_MS    = 1;
  localparam int               CYCLE_LIMIT     = 600000;
  localparam int               HOLD_OFF_CYCLES = 400;
  localparam int               PHASES          = 9;
  localparam int               SCANS_PER_PHASE = 110;
  localparam logic [IDX_W-1:0] REG_UNUSED      = 3'd7;

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              in_valid_i        = 1'b0;
  logic              in_ready_o;
  logic              first_pressed_i   = 1'b0;
  logic              second_pressed_i  = 1'b0;
  logic [TIME_W-1:0] now_tick_i        = '0;
  logic [TIME_W-1:0] rand_socd_i       = '0;
  logic [TIME_W-1:0] rand_tap_delay_i  = '0;
  logic [TIME_W-1:0] rand_tap_length_i = '0;
  logic              out_valid_o;
  logic              out_ready_i       = 1'b0;
  logic              first_out_o;
  logic              second_out_o;
  logic              psel              = 1'b0;
  logic              penable           = 1'b0;
  logic              pwrite            = 1'b0;
  logic [ADDR_W-1:0] paddr             = '0;
  logic [DATA_W-1:0] pwdata            = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_count_o;
  int                expect_depth_o;

  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_off_asks = 0;
  int                hold_off_seen = 0;
  int                stall_left    = 0;
  int                cycle_count   = 0;
  int                tick_span     = 3;
  logic [TIME_W-1:0] scan_tick     = '0;
  logic              key_first     = 1'b0;
  logic              key_second    = 1'b0;

  opposing_key_pair_resolver #(.TICKS_PER_MS(TICKS_PER_MS)) dut (.*);

  resolved_keys_checker #(.TICKS_PER_MS(TICKS_PER_MS)) checker_inst (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("opposing_key_pair_resolver regression: fail");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off whenever asked.
  always @(negedge clk_i) begin
    if (hold_off_seen != hold_off_asks) begin
      hold_off_seen = hold_off_asks;
      stall_left    = HOLD_OFF_CYCLES;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_setting(input logic [IDX_W-1:0] idx, input logic [31:0] value,
                               input int bits);
    logic [31:0] keep;
    keep = (bits >= 32) ? '1 : ((32'd1 << bits) - 32'd1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // Bits above the register width carry noise and must be dropped.
    pwdata  <= (value & keep) | ($urandom & ~keep);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  task automatic load_settings(input cfg_t cfg);
    write_setting(REG_SOCD_ENABLE, 32'(cfg.socd_enable), 1);
    write_setting(REG_SOCD_RANDOMIZE, 32'(cfg.socd_randomize), 1);
    write_setting(REG_SOCD_DELAY, 32'(cfg.socd_delay), MS_W);
    write_setting(REG_TAP_ENABLE, 32'(cfg.tap_enable), 1);
    write_setting(REG_TAP_RANDOMIZE, 32'(cfg.tap_randomize), 1);
    write_setting(REG_TAP_DELAY, 32'(cfg.tap_delay), MS_W);
    write_setting(REG_TAP_DURATION, 32'(cfg.tap_duration), MS_W);
    write_setting(REG_UNUSED, $urandom, 32);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic offer_scan(input logic f, input logic s, input logic [TIME_W-1:0] now,
                            input logic [TIME_W-1:0] socd_word,
                            input logic [TIME_W-1:0] delay_word,
                            input logic [TIME_W-1:0] length_word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    first_pressed_i   <= f;
    second_pressed_i  <= s;
    now_tick_i        <= now;
    rand_socd_i       <= socd_word;
    rand_tap_delay_i  <= delay_word;
    rand_tap_length_i <= length_word;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (expect_depth_o != 0) @(negedge clk_i);
  endtask

  // Mostly a walk of the physical keys with small tick steps so that deadlines
  // come due while keys are held or released; now and then the tick jumps.
  task automatic random_scan();
    int roll;
    roll = $urandom_range(99);
    if (roll < 12) begin
      key_first  = 1'b0;
      key_second = 1'b0;
    end else if (roll < 20) begin
      key_first  = 1'($urandom_range(1));
      key_second = 1'($urandom_range(1));
    end else begin
      if ($urandom_range(3) == 0) key_first = ~key_first;
      if ($urandom_range(3) == 0) key_second = ~key_second;
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      scan_tick = $urandom;
    end else if (roll < 8) begin
      scan_tick = scan_tick + $urandom_range(0, 600);
    end else begin
      scan_tick = scan_tick + $urandom_range(0, tick_span);
    end
    offer_scan(key_first, key_second, scan_tick, $urandom, $urandom, $urandom);
  endtask

  initial begin
    cfg_t phase_cfg;
    int   longest;
    send_idle_pct = 23;
    recv_idle_pct = 72;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Pass-through right after reset: both keys go down with no winner.
    offer_scan(1'b1, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0);
    wait_until_drained();
    // Field order: socd enable, randomize, delay, tap enable, randomize, delay, duration.
    load_settings({1'b1, 1'b0, 8'd3, 1'b1, 1'b0, 8'd2, 8'd3});
    // Both held with no winner and no edge: the second key wins.
    offer_scan(1'b1, 1'b1, 32'd1, '1, '1, '1);
    // Both released in one scan: no tap.
    offer_scan(1'b0, 1'b0, 32'd2, 32'd0, 32'd0, 32'd0);
    offer_scan(1'b1, 1'b0, 32'd3, '1, 32'd0, '1);
    // Second key pressed over the first: nothing reported until the deadline.
    offer_scan(1'b1, 1'b1, 32'd4, 32'd0, '1, 32'd0);
    offer_scan(1'b1, 1'b1, 32'd6, '1, '1, '1);
    offer_scan(1'b1, 1'b1, 32'd7, 32'd0, 32'd0, 32'd0);
    offer_scan(1'b0, 1'b1, 32'd8, '1, 32'd0, '1);
    // Release of the second key schedules a tap of the first one.
    offer_scan(1'b0, 1'b0, 32'd9, 32'd0, '1, 32'd0);
    offer_scan(1'b0, 1'b0, 32'd10, '1, '1, '1);
    offer_scan(1'b0, 1'b0, 32'd12, 32'd0, 32'd0, 32'd0);
    offer_scan(1'b0, 1'b0, 32'd14, '1, 32'd0, '1);
    // Both newly pressed together: the first key wins.
    offer_scan(1'b1, 1'b1, 32'hFFFF_FFFE, 32'd0, '1, 32'd0);
    offer_scan(1'b0, 1'b0, 32'hFFFF_FFFF, '1, '1, '1);
    offer_scan(1'b0, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    // A tap window that straddles the tick wrap, then cut short by a press.
    offer_scan(1'b0, 1'b0, 32'hFFFF_FFFF, '1, 32'd0, '1);
    offer_scan(1'b0, 1'b0, 32'd2, 32'd0, '1, 32'd0);
    offer_scan(1'b1, 1'b0, 32'd3, '1, '1, '1);
    // A switch deadline crossing the signed boundary of the tick difference.
    offer_scan(1'b1, 1'b1, 32'h7FFF_FFF0, 32'd0, 32'd0, 32'd0);
    offer_scan(1'b1, 1'b1, 32'h8000_0000, '1, 32'd0, '1);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 72;
      end else if (phase < 6) begin
        send_idle_pct = 72;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: phase_cfg = {1'b1, 1'b0, 8'd0, 1'b1, 1'b0, 8'd0, 8'd1};
        1: phase_cfg = {1'b1, 1'b1, 8'd255, 1'b1, 1'b1, 8'd255, 8'd255};
        2: phase_cfg = {1'b1, 1'b0, 8'd255, 1'b1, 1'b0, 8'd255, 8'd255};
        3: phase_cfg = '0;
        4: phase_cfg = {1'b1, 1'b1, 8'd1, 1'b1, 1'b1, 8'd1, 8'd1};
        5: phase_cfg = {1'b0, 1'b1, 8'd20, 1'b1, 1'b0, 8'd5, 8'd0};
        7: phase_cfg = {1'b1, 1'b0, 8'd8, 1'b1, 1'b1, 8'd12, 8'd30};
        default: begin
          phase_cfg = cfg_t'(($bits(cfg_t))'($urandom));
          phase_cfg.socd_enable = 1'b1;
          phase_cfg.tap_enable  = 1'b1;
          phase_cfg.socd_delay  = MS_W'($urandom_range(0, 40));
          phase_cfg.tap_delay   = MS_W'($urandom_range(0, 40));
          phase_cfg.tap_duration = MS_W'($urandom_range(0, 40));
        end
      endcase
      wait_until_drained();
      load_settings(phase_cfg);
      longest = phase_cfg.tap_delay + phase_cfg.tap_duration;
      if (phase_cfg.socd_delay > longest) longest = phase_cfg.socd_delay;
      tick_span = 3 + longest / 4;
      if (phase == 4) scan_tick = 32'hFFFF_FF00;
      if (phase == 1 || phase == 7) hold_off_asks++;
      repeat (SCANS_PER_PHASE) random_scan();
    end

    wait_until_drained();
    repeat (40) @(negedge clk_i);
    if (fail_count_o == 0 && expect_depth_o == 0) begin
      $display("opposing_key_pair_resolver regression: pass");
    end else begin
      $display("opposing_key_pair_resolver regression: fail");
    end
    $finish;
  end

endmodule
